@@ rtl/rnta_pkg.sv @@
// Shared constants, types and the digit-to-character function for the ASCII converter.
`timescale 1ns / 1ps

package rnta_pkg;

	localparam int ValueW    = 64;
	localparam int DigitW    = 4;
	localparam int DecDigits = 20;
	localparam int HexDigits = 16;
	localparam int BinDigits = 64;
	localparam int BcdW      = DecDigits * DigitW;
	localparam int CntW      = 7;
	localparam int IterW     = 6;
	localparam int CharW     = 8;

	typedef enum logic [1:0] {
		OP_DEC = 2'd0,
		OP_HEX = 2'd1,
		OP_BIN = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
		logic [CharW-1:0] c;
		if (d < DigitW'(10)) begin
			c = 8'h30 + {4'b0, d};
		end else begin
			c = 8'h41 + {4'b0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

@@ rtl/radix_number_to_ascii.sv @@
// Top level: radix sequencer, digit shifter and output register.
`timescale 1ns / 1ps
//
// Renders an unsigned 64-bit value as ASCII digits, most significant first.
// Input channel: in_valid/in_ready with value and opcode (0 decimal,
// 1 hex uppercase, 2 binary, 3 dropped with no output).
// Output channel: out_valid/out_ready with ascii_char and last; one
// character per transfer, last marks the final character of the number.
// Steps from one input transfer to the next:
//   decimal: conversion in the shift-add-3 unit, skip of leading zeros,
//            emit of each character, return to idle.
//   hex:     skip of leading zeros, emit of each character, return to idle.
//   binary:  emit of all 64 characters, return to idle.
//   Opcode 3: taken and dropped while idle.
// The emit state writes each character into the output register once it is free.
// in_ready is high only while the sequencer is idle; a new item may be
// taken while the final character still waits in the output register.
// A stalled receiver holds the output register and, in the emit state, freezes the shifter.
// Reset empties the output register and returns the sequencer to idle.

module radix_number_to_ascii (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rnta_pkg::ValueW-1:0]    value,
	input  logic [1:0]                     opcode,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rnta_pkg::CharW-1:0]     ascii_char,
	output logic                           last
);

	rnta_pkg::state_t              state_q, state_d;
	logic                          bcd_start;
	logic                          bcd_done;
	rnta_pkg::op_t                 op;
	logic [rnta_pkg::BcdW-1:0]     bcd;
	logic [rnta_pkg::BcdW-1:0]     word_q;
	logic [rnta_pkg::CntW-1:0]     cnt_q;
	logic                          bin_q;
	logic                          ov_q;
	logic [rnta_pkg::CharW-1:0]    char_q;
	logic                          last_q;
	logic                          in_xfer;
	logic                          slot_free;
	logic                          skip_more;
	logic [rnta_pkg::DigitW-1:0]   top_digit;

	assign op        = rnta_pkg::op_t'(opcode);
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !ov_q || out_ready;
	assign top_digit = bin_q ? {3'b000, word_q[rnta_pkg::BcdW-1]}
		: word_q[rnta_pkg::BcdW-1 -: rnta_pkg::DigitW];
	assign skip_more = (cnt_q > rnta_pkg::CntW'(1)) &&
		(word_q[rnta_pkg::BcdW-1 -: rnta_pkg::DigitW] == '0);

	rnta_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (value),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rnta_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (op)
						rnta_pkg::OP_DEC:  state_d = rnta_pkg::ST_CONV;
						rnta_pkg::OP_HEX:  state_d = rnta_pkg::ST_SKIP;
						rnta_pkg::OP_BIN:  state_d = rnta_pkg::ST_EMIT;
						rnta_pkg::OP_NONE: state_d = rnta_pkg::ST_IDLE;
						default:           state_d = rnta_pkg::ST_IDLE;
					endcase
				end
			end
			rnta_pkg::ST_CONV: begin
				if (bcd_done) begin
					state_d = rnta_pkg::ST_SKIP;
				end
			end
			rnta_pkg::ST_SKIP: begin
				if (!skip_more) begin
					state_d = rnta_pkg::ST_EMIT;
				end
			end
			rnta_pkg::ST_EMIT: begin
				if (slot_free && cnt_q == rnta_pkg::CntW'(1)) begin
					state_d = rnta_pkg::ST_IDLE;
				end
			end
			default: state_d = rnta_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		bcd_start = 1'b0;
		unique case (state_q)
			rnta_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				bcd_start = in_valid && op == rnta_pkg::OP_DEC;
			end
			rnta_pkg::ST_CONV,
			rnta_pkg::ST_SKIP,
			rnta_pkg::ST_EMIT: begin
				in_ready = 1'b0;
			end
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rnta_pkg::ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rnta_pkg::ST_EMIT && slot_free) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// digit shifter and output payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			rnta_pkg::ST_IDLE: begin
				if (in_xfer) begin
					word_q <= {value, {(rnta_pkg::BcdW - rnta_pkg::ValueW){1'b0}}};
					bin_q  <= (op == rnta_pkg::OP_BIN);
					cnt_q  <= (op == rnta_pkg::OP_BIN) ? rnta_pkg::CntW'(rnta_pkg::BinDigits)
						: rnta_pkg::CntW'(rnta_pkg::HexDigits);
				end
			end
			rnta_pkg::ST_CONV: begin
				if (bcd_done) begin
					word_q <= bcd;
					cnt_q  <= rnta_pkg::CntW'(rnta_pkg::DecDigits);
				end
			end
			rnta_pkg::ST_SKIP: begin
				if (skip_more) begin
					word_q <= {word_q[rnta_pkg::BcdW-rnta_pkg::DigitW-1:0],
						{rnta_pkg::DigitW{1'b0}}};
					cnt_q  <= cnt_q - 1'b1;
				end
			end
			rnta_pkg::ST_EMIT: begin
				if (slot_free) begin
					char_q <= rnta_pkg::digit_char(top_digit);
					last_q <= (cnt_q == rnta_pkg::CntW'(1));
					cnt_q  <= cnt_q - 1'b1;
					if (bin_q) begin
						word_q <= {word_q[rnta_pkg::BcdW-2:0], 1'b0};
					end else begin
						word_q <= {word_q[rnta_pkg::BcdW-rnta_pkg::DigitW-1:0],
							{rnta_pkg::DigitW{1'b0}}};
					end
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign out_valid  = ov_q;
	assign ascii_char = char_q;
	assign last       = last_q;

endmodule

@@ rtl/rnta_bcd.sv @@
// Iterative binary to BCD converter, one shift-add-3 step per cycle.
`timescale 1ns / 1ps

module rnta_bcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rnta_pkg::ValueW-1:0]   value,
	output logic                          done,
	output logic [rnta_pkg::BcdW-1:0]     bcd
);

	logic                          busy_q;
	logic                          done_q;
	logic [rnta_pkg::IterW-1:0]    iter_q;
	logic [rnta_pkg::ValueW-1:0]   bin_q;
	logic [rnta_pkg::BcdW-1:0]     bcd_q;
	logic [rnta_pkg::BcdW-1:0]     adj;

	always_comb begin
		for (int i = 0; i < rnta_pkg::DecDigits; i++) begin
			if (bcd_q[i*rnta_pkg::DigitW +: rnta_pkg::DigitW] >= rnta_pkg::DigitW'(5)) begin
				adj[i*rnta_pkg::DigitW +: rnta_pkg::DigitW] =
					bcd_q[i*rnta_pkg::DigitW +: rnta_pkg::DigitW] + rnta_pkg::DigitW'(3);
			end else begin
				adj[i*rnta_pkg::DigitW +: rnta_pkg::DigitW] =
					bcd_q[i*rnta_pkg::DigitW +: rnta_pkg::DigitW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == {rnta_pkg::IterW{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[rnta_pkg::ValueW-2:0], 1'b0};
			bcd_q <= {adj[rnta_pkg::BcdW-2:0], bin_q[rnta_pkg::ValueW-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

@@ bench/tb_radix_number_to_ascii.sv @@
// Testbench for radix_number_to_ascii: directed table, then random traffic checked per character.
`timescale 1ns / 1ps

module tb_radix_number_to_ascii;

	typedef struct packed {
		logic [rnta_pkg::CharW-1:0] ch;
		logic                       last;
	} glyph_t;

	typedef struct {
		logic [rnta_pkg::ValueW-1:0] value;
		rnta_pkg::op_t               op;
		bit                          typed;
		string                       text;
	} stim_row_t;

	localparam string Glyphs = "0123456789ABCDEF";
	localparam int    TableRows = 22;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [rnta_pkg::ValueW-1:0] value = '0;
	logic [1:0]                  opcode = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [rnta_pkg::CharW-1:0]  ascii_char;
	logic                        last;

	glyph_t    pending_chars[$];
	stim_row_t stim_table[TableRows];
	int        mismatches = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;

	radix_number_to_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ascii_char(ascii_char),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// expected character run for one accepted number
	function automatic void render_digits(logic [rnta_pkg::ValueW-1:0] v, rnta_pkg::op_t op);
		byte unsigned digits[$];
		glyph_t       g;
		case (op)
			rnta_pkg::OP_DEC: begin
				do begin
					digits.push_front(Glyphs[int'(v % 64'd10)]);
					v = v / 64'd10;
				end while (v != '0);
			end
			rnta_pkg::OP_HEX: begin
				do begin
					digits.push_front(Glyphs[int'(v[3:0])]);
					v = v >> 4;
				end while (v != '0);
			end
			rnta_pkg::OP_BIN: begin
				for (int i = rnta_pkg::BinDigits - 1; i >= 0; i--) begin
					digits.push_back(Glyphs[int'(v[i])]);
				end
			end
			default: ;
		endcase
		foreach (digits[i]) begin
			g.ch = digits[i];
			g.last = (i == digits.size() - 1);
			pending_chars.push_back(g);
		end
	endfunction

	function automatic void expect_text(string s);
		glyph_t g;
		for (int i = 0; i < s.len(); i++) begin
			g.ch = s[i];
			g.last = (i == s.len() - 1);
			pending_chars.push_back(g);
		end
	endfunction

	always @(posedge clk) begin
		glyph_t want;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected char 0x%02h last=%0b", ascii_char, last);
				end
			end else begin
				want = pending_chars.pop_front();
				if (ascii_char !== want.ch || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("char mismatch: exp 0x%02h last=%0b, got 0x%02h last=%0b",
							want.ch, want.last, ascii_char, last);
					end
				end
			end
		end
	end

	task automatic send_number(logic [rnta_pkg::ValueW-1:0] v, rnta_pkg::op_t op);
		in_valid <= 1'b1;
		value <= v;
		opcode <= op;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic sender_gap();
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 90)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	task automatic random_numbers(int count);
		int                          done_items;
		logic [rnta_pkg::ValueW-1:0] v;
		rnta_pkg::op_t               op;
		done_items = 0;
		while (done_items < count) begin
			v = {$urandom, $urandom};
			case ($urandom_range(7))
				0, 1: ;
				2: v = v >> $urandom_range(0, 63);
				3: v = '1;
				default: v = v >> $urandom_range(20, 63);
			endcase
			if ($urandom_range(99) < 5) begin
				op = rnta_pkg::OP_NONE;
			end else begin
				op = rnta_pkg::op_t'($urandom_range(0, 2));
				done_items++;
			end
			send_number(v, op);
			render_digits(v, op);
			sender_gap();
		end
	endtask

	initial begin
		stim_table = '{
			'{64'd0, rnta_pkg::OP_DEC, 1'b1, "0"},
			'{64'd0, rnta_pkg::OP_HEX, 1'b1, "0"},
			'{64'd0, rnta_pkg::OP_BIN, 1'b0, ""},
			'{'1, rnta_pkg::OP_DEC, 1'b1, "18446744073709551615"},
			'{'1, rnta_pkg::OP_HEX, 1'b1, "FFFFFFFFFFFFFFFF"},
			'{'1, rnta_pkg::OP_BIN, 1'b0, ""},
			'{64'd1, rnta_pkg::OP_DEC, 1'b1, "1"},
			'{64'd9, rnta_pkg::OP_DEC, 1'b1, "9"},
			'{64'd10, rnta_pkg::OP_DEC, 1'b1, "10"},
			'{64'd15, rnta_pkg::OP_HEX, 1'b1, "F"},
			'{64'd16, rnta_pkg::OP_HEX, 1'b1, "10"},
			'{64'hABCD_EF01_2345_6789, rnta_pkg::OP_HEX, 1'b1, "ABCDEF0123456789"},
			'{64'd1234567890, rnta_pkg::OP_DEC, 1'b1, "1234567890"},
			'{64'h5555_5555_5555_5555, rnta_pkg::OP_NONE, 1'b1, ""},
			'{64'd1, rnta_pkg::OP_BIN, 1'b0, ""},
			'{64'h8000_0000_0000_0000, rnta_pkg::OP_BIN, 1'b0, ""},
			'{64'd0, rnta_pkg::OP_NONE, 1'b1, ""},
			'{64'd10000000000000000000, rnta_pkg::OP_DEC, 1'b1, "10000000000000000000"},
			'{64'd9999999999999999999, rnta_pkg::OP_DEC, 1'b1, "9999999999999999999"},
			'{64'h0FFF_FFFF_FFFF_FFFF, rnta_pkg::OP_HEX, 1'b1, "FFFFFFFFFFFFFFF"},
			'{64'h1000_0000_0000_0000, rnta_pkg::OP_HEX, 1'b1, "1000000000000000"},
			'{64'hAAAA_AAAA_AAAA_AAAA, rnta_pkg::OP_BIN, 1'b0, ""}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 29;
		rx_idle_pct = 85;
		foreach (stim_table[i]) begin
			send_number(stim_table[i].value, stim_table[i].op);
			if (stim_table[i].typed) begin
				expect_text(stim_table[i].text);
			end else begin
				render_digits(stim_table[i].value, stim_table[i].op);
			end
			sender_gap();
		end
		drain();

		random_numbers(130);
		drain();
		tx_idle_pct = 85;
		rx_idle_pct = 29;
		random_numbers(130);
		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_numbers(130);
		drain();

		// let a trailing dropped item or stray transfer surface
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ radix_number_to_ascii.f @@
rtl/rnta_pkg.sv
rtl/rnta_bcd.sv
rtl/radix_number_to_ascii.sv
bench/tb_radix_number_to_ascii.sv
